[rtl/preorder_bst_validator_assert.svh]
// ----------------------------------------------------------------------------
// preorder_bst_validator_assert.svh
// Assertion macros shared by the preorder tree validator modules.
// ----------------------------------------------------------------------------
`ifndef PREORDER_BST_VALIDATOR_ASSERT_SVH
`define PREORDER_BST_VALIDATOR_ASSERT_SVH

// Checks a property at every rising clock edge outside reset.
`define PBV_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Checks that a condition never holds at a rising clock edge outside reset.
`define PBV_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    `PBV_ASSERT(label, clk, rst_n, !(cond), msg)

`endif

[rtl/pbv_pkg.sv]
// ----------------------------------------------------------------------------
// pbv_pkg
// Types and constants shared by the preorder tree validator modules.
// ----------------------------------------------------------------------------
package pbv_pkg;

    // Width of the key field on the input stream.
    localparam int KEY_IN_W = 32;

    // Width of the verdict and of the byte-padded output data bus.
    localparam int STATUS_W = 2;
    localparam int OUT_TDATA_W = 8;

    // Depth of the queue between the front and the back part.
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_VALID      = 2'd0,
        STATUS_VIOLATION  = 2'd1,
        STATUS_INCOMPLETE = 2'd2,
        STATUS_DEPTH      = 2'd3
    } status_t;

    typedef enum logic {
        TOKEN_KEY  = 1'b0,
        TOKEN_NULL = 1'b1
    } token_kind_t;

    // Control part of a classified token.
    typedef struct packed {
        token_kind_t kind;
        logic        last;
    } token_ctl_t;

endpackage

[rtl/pbv_front.sv]
// ----------------------------------------------------------------------------
// pbv_front
// Accepts input tokens and classifies them into a kind, a last flag and a key.
// ----------------------------------------------------------------------------
module pbv_front
    import pbv_pkg::*;
#(
    parameter int KEY_WIDTH = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [KEY_IN_W-1:0]  in_data,
    input  logic                 in_null,
    input  logic                 in_last,
    output logic                 push_valid,
    input  logic                 push_ready,
    output token_ctl_t           push_ctl,
    output logic [KEY_WIDTH-1:0] push_key
);

    logic [KEY_IN_W+KEY_WIDTH-1:0] key_wide;
    logic                          seen_reg;
    logic                          seen_next;

    // The key is the low KEY_WIDTH bits of the raw field, zero filled above.
    assign key_wide = {{KEY_WIDTH{1'b0}}, in_data};

    assign in_ready      = push_ready;
    assign push_valid    = in_valid;
    assign push_key      = key_wide[KEY_WIDTH-1:0];
    assign push_ctl.kind = in_null ? TOKEN_NULL : TOKEN_KEY;
    assign push_ctl.last = in_last;

    // Tracks whether a request of the current stream is in flight.
    always_comb
    begin
        seen_next = seen_reg;
        if (in_valid && push_ready)
        begin
            seen_next = !in_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg <= 1'b0;
        end
        else
        begin
            seen_reg <= seen_next;
        end
    end

endmodule

[rtl/pbv_queue.sv]
// ----------------------------------------------------------------------------
// pbv_queue
// Short register FIFO that decouples the front part from the back part.
// ----------------------------------------------------------------------------
module pbv_queue
    import pbv_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entries [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entries[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        unique case ({do_push, do_pop})
            2'b10:   count_next = count_reg + CNT_W'(1);
            2'b01:   count_next = count_reg - CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[rtl/pbv_back.sv]
// ----------------------------------------------------------------------------
// pbv_back
// Bound-stack engine: checks each token and produces the verdict.
// ----------------------------------------------------------------------------
`include "preorder_bst_validator_assert.svh"

module pbv_back
    import pbv_pkg::*;
#(
    parameter int STACK_DEPTH = 64,
    parameter int KEY_WIDTH   = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    output logic                 q_ready,
    input  token_ctl_t           q_ctl,
    input  logic [KEY_WIDTH-1:0] q_key,
    output logic                 out_valid,
    input  logic                 out_ready,
    output status_t              out_status
);

    localparam int BW    = KEY_WIDTH + 1;
    localparam int IDX_W = $clog2(STACK_DEPTH);
    localparam int CNT_W = $clog2(STACK_DEPTH + 1);
    localparam logic signed [BW-1:0] KEY_MAX = {2'b00, {(KEY_WIDTH-1){1'b1}}};
    localparam logic signed [BW-1:0] KEY_MIN = ~KEY_MAX;

    // Stack entries below the top; the top pair lives in registers.
    logic signed [BW-1:0] lo_mem [STACK_DEPTH];
    logic signed [BW-1:0] hi_mem [STACK_DEPTH];

    logic signed [BW-1:0] top_lo_reg, top_lo_next;
    logic signed [BW-1:0] top_hi_reg, top_hi_next;
    logic signed [BW-1:0] rd_lo_reg;
    logic signed [BW-1:0] rd_hi_reg;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic                 started_reg, started_next;
    logic                 complete_reg, complete_next;
    logic                 violation_reg, violation_next;
    logic                 exceeded_reg, exceeded_next;
    logic                 pend_reg, pend_next;
    logic                 out_valid_reg, out_valid_next;
    status_t              out_status_reg, out_status_next;

    logic signed [BW-1:0] key_ext;
    logic signed [BW-1:0] key_p1;
    logic signed [BW-1:0] key_m1;
    logic signed [BW-1:0] eff_lo;
    logic signed [BW-1:0] eff_hi;
    logic [CNT_W-1:0]     eff_count;
    logic [CNT_W-1:0]     wr_cnt;
    logic [CNT_W-1:0]     rd_cnt;
    logic [IDX_W-1:0]     wr_idx;
    logic [IDX_W-1:0]     rd_idx;
    logic                 active;
    logic                 pop;
    logic                 mem_we;
    logic                 rd_en;

    assign key_ext = {q_key[KEY_WIDTH-1], q_key};
    assign key_p1  = key_ext + BW'(1);
    assign key_m1  = key_ext - BW'(1);

    // Before the first token the top pair is the full key range.
    assign eff_lo    = !started_reg ? KEY_MIN : (pend_reg ? rd_lo_reg : top_lo_reg);
    assign eff_hi    = !started_reg ? KEY_MAX : (pend_reg ? rd_hi_reg : top_hi_reg);
    assign eff_count = started_reg ? count_reg : CNT_W'(1);
    assign wr_cnt    = eff_count - CNT_W'(1);
    assign rd_cnt    = eff_count - CNT_W'(2);
    assign wr_idx    = wr_cnt[IDX_W-1:0];
    assign rd_idx    = rd_cnt[IDX_W-1:0];

    assign active  = !complete_reg && !exceeded_reg;
    assign pop     = q_valid && (!q_ctl.last || !out_valid_reg || out_ready);
    assign q_ready = pop;

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;

    always_comb
    begin
        top_lo_next     = top_lo_reg;
        top_hi_next     = top_hi_reg;
        count_next      = count_reg;
        started_next    = started_reg;
        complete_next   = complete_reg;
        violation_next  = violation_reg;
        exceeded_next   = exceeded_reg;
        pend_next       = pend_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_status_next = out_status_reg;
        mem_we          = 1'b0;
        rd_en           = 1'b0;
        if (pop)
        begin
            if (active)
            begin
                started_next = 1'b1;
                unique case (q_ctl.kind)
                    TOKEN_KEY:
                    begin
                        if (key_ext < eff_lo || key_ext > eff_hi)
                        begin
                            violation_next = 1'b1;
                        end
                        if (eff_count == CNT_W'(STACK_DEPTH))
                        begin
                            exceeded_next = 1'b1;
                        end
                        else
                        begin
                            // Right subtree bounds go below, left subtree bounds on top.
                            mem_we      = 1'b1;
                            top_lo_next = eff_lo;
                            top_hi_next = key_m1;
                            count_next  = eff_count + CNT_W'(1);
                            pend_next   = 1'b0;
                        end
                    end
                    TOKEN_NULL:
                    begin
                        count_next = wr_cnt;
                        if (wr_cnt == '0)
                        begin
                            complete_next = 1'b1;
                            pend_next     = 1'b0;
                        end
                        else
                        begin
                            // The new top pair arrives from memory next cycle.
                            pend_next = 1'b1;
                            rd_en     = 1'b1;
                        end
                    end
                    default:
                    begin
                        pend_next = pend_reg;
                    end
                endcase
            end
            if (q_ctl.last)
            begin
                out_valid_next = 1'b1;
                priority if (exceeded_next)
                begin
                    out_status_next = STATUS_DEPTH;
                end
                else if (violation_next)
                begin
                    out_status_next = STATUS_VIOLATION;
                end
                else if (!complete_next)
                begin
                    out_status_next = STATUS_INCOMPLETE;
                end
                else
                begin
                    out_status_next = STATUS_VALID;
                end
                count_next     = '0;
                started_next   = 1'b0;
                complete_next  = 1'b0;
                violation_next = 1'b0;
                exceeded_next  = 1'b0;
                pend_next      = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            started_reg    <= 1'b0;
            complete_reg   <= 1'b0;
            violation_reg  <= 1'b0;
            exceeded_reg   <= 1'b0;
            pend_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= STATUS_VALID;
        end
        else
        begin
            count_reg      <= count_next;
            started_reg    <= started_next;
            complete_reg   <= complete_next;
            violation_reg  <= violation_next;
            exceeded_reg   <= exceeded_next;
            pend_reg       <= pend_next;
            out_valid_reg  <= out_valid_next;
            out_status_reg <= out_status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_lo_reg <= top_lo_next;
        top_hi_reg <= top_hi_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            lo_mem[wr_idx] <= key_p1;
            hi_mem[wr_idx] <= eff_hi;
        end
        if (rd_en)
        begin
            rd_lo_reg <= lo_mem[rd_idx];
            rd_hi_reg <= hi_mem[rd_idx];
        end
    end

    `PBV_ASSERT(a_pend_needs_stack, clk, rst_n,
        pend_reg |-> (started_reg && count_reg != '0 && !complete_reg),
        "memory refill pending without a live stack")
    `PBV_ASSERT(a_complete_empty, clk, rst_n,
        complete_reg |-> (count_reg == '0 && !exceeded_reg),
        "tree complete while the stack still holds bounds")
    `PBV_ASSERT_NEVER(a_no_verdict_overrun, clk, rst_n,
        q_valid && q_ctl.last && out_valid_reg && !out_ready && pop,
        "verdict taken from queue while the output register is full")
    `PBV_ASSERT(a_count_bound, clk, rst_n,
        count_reg <= CNT_W'(STACK_DEPTH),
        "bound stack count beyond its depth")

endmodule

[rtl/preorder_bst_validator.sv]
// ----------------------------------------------------------------------------
// preorder_bst_validator
// Checks a preorder token stream with empty markers for the search tree order.
// ----------------------------------------------------------------------------
// The block takes one token per cycle on the slave stream while the queue has
// room, which it lacks only while a verdict stalls on the master stream. Each
// token is one update of the bound stack, whose top pair is held in registers
// while the rest lives in a memory with one write and one registered read
// port. A key token writes the right subtree bounds to memory and keeps the
// left subtree bounds on top; an empty marker starts a memory read whose data
// serves as the new top pair in the following cycle, so consecutive tokens
// never wait on each other. An accepted token is registered in the two-entry
// queue, and the verdict of a request with tlast set is registered when the
// back part pops that request. Only requests with tlast produce a verdict;
// it is 0 for a valid tree, 1 for an ordering violation, 2 for an incomplete
// tree and 3 when the bound stack overflowed, with precedence 3, 1, 2, 0.
// Tokens after the tree is complete are ignored, and after each verdict the
// next token starts a new tree. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module preorder_bst_validator
    import pbv_pkg::*;
#(
    parameter int STACK_DEPTH = 64,
    parameter int KEY_WIDTH   = 32
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [KEY_IN_W-1:0]    s_axis_tdata,  // key
    input  logic [0:0]             s_axis_tuser,  // is_null
    input  logic                   s_axis_tlast,  // last_token
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata   // status, zero padded
);

    localparam int TOKEN_W = KEY_WIDTH + $bits(token_ctl_t);

    logic                 push_valid;
    logic                 push_ready;
    token_ctl_t           push_ctl;
    logic [KEY_WIDTH-1:0] push_key;
    logic                 pop_valid;
    logic                 pop_ready;
    logic [TOKEN_W-1:0]   pop_data;
    token_ctl_t           pop_ctl;
    logic [KEY_WIDTH-1:0] pop_key;
    status_t              status;

    // Front part: takes requests and splits them into kind, last flag and key.
    pbv_front #(
        .KEY_WIDTH (KEY_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_data    (s_axis_tdata),
        .in_null    (s_axis_tuser[0]),
        .in_last    (s_axis_tlast),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_ctl   (push_ctl),
        .push_key   (push_key)
    );

    // The queue lets the front keep accepting while the verdict output stalls, until it is full.
    pbv_queue #(
        .WIDTH (TOKEN_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  ({push_key, push_ctl}),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    assign pop_ctl = token_ctl_t'(pop_data[$bits(token_ctl_t)-1:0]);
    assign pop_key = pop_data[TOKEN_W-1:$bits(token_ctl_t)];

    // Back part: bound stack, ordering check and verdict register.
    pbv_back #(
        .STACK_DEPTH (STACK_DEPTH),
        .KEY_WIDTH   (KEY_WIDTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (pop_valid),
        .q_ready    (pop_ready),
        .q_ctl      (pop_ctl),
        .q_key      (pop_key),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_status (status)
    );

    assign m_axis_tdata = {{(OUT_TDATA_W-STATUS_W){1'b0}}, status};

endmodule
